@@ rtl/grouped_interrupt_status_mask_ctrl_macros.svh @@
// Assertion macros shared by the interrupt controller RTL.
`ifndef GROUPED_INTERRUPT_STATUS_MASK_CTRL_MACROS_SVH
`define GROUPED_INTERRUPT_STATUS_MASK_CTRL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GISM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GISM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gism_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gism_pkg;

    localparam int GROUPS = 3;
    localparam int LEVELS = 3;
    localparam int MASKS  = GROUPS * LEVELS;

    typedef enum logic [1:0] {
        CMD_RAISE = 2'd0,
        CMD_LOWER = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } t_command;

    // Register map: three status groups, then the masks level by level.
    localparam logic [3:0] REG_STATUS_NRM = 4'd0;
    localparam logic [3:0] REG_MASK_BASE  = 4'd3;
    localparam logic [3:0] REG_END        = 4'd12;

    localparam logic [1:0] GROUP_NRM = 2'd0;
    localparam logic [1:0] GROUP_EXT = 2'd1;
    localparam logic [1:0] GROUP_ERR = 2'd2;
    localparam logic [1:0] GROUP_END = 2'd3;

    localparam logic [31:0] NRM_LOW_MASK = 32'h3fff_ffff;
    localparam logic [31:0] FLAG_EXT     = 32'h4000_0000;
    localparam logic [31:0] FLAG_ERR     = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] read_data;
        logic        level6_request;
        logic        level4_request;
        logic        level2_request;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/grouped_interrupt_status_mask_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-------------------------------------------
// command   | in        | i_valid / o_stall   | command, irq_group, irq_bits, reg_index,
//           |           |                     | write_data
// result    | out       | o_valid / i_stall   | read_data, level6/4/2 requests
//
// Every command is one transaction in and exactly one transaction out; a new command can be
// taken on every clock while o_stall is low. The status/mask update and the AND-OR of the
// level requests are combinational; their result is registered in the output stage.
// Reset is synchronous and active low; it clears all status and mask registers to zero.
// A two-entry output stage (result register plus skid register) lets a command enter while
// a result is held by downstream stall; o_stall rises only once both entries are full.

`include "grouped_interrupt_status_mask_ctrl_macros.svh"

module grouped_interrupt_status_mask_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [1:0]  i_irq_group,
    input  wire logic [31:0] i_irq_bits,
    input  wire logic [3:0]  i_reg_index,
    input  wire logic [31:0] i_write_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_read_data,
    output logic             o_level6_request,
    output logic             o_level4_request,
    output logic             o_level2_request
);

    // Architectural state: one status word per group and one mask per group and level.
    logic [31:0] r_status [gism_pkg::GROUPS];
    logic [31:0] r_mask   [gism_pkg::MASKS];
    logic [31:0] n_status [gism_pkg::GROUPS];
    logic [31:0] n_mask   [gism_pkg::MASKS];

    // Output stage.
    gism_pkg::t_result r_out;
    gism_pkg::t_result r_skid;
    gism_pkg::t_result n_result;
    logic              r_out_vld;
    logic              r_skid_vld;

    gism_pkg::t_command cmd;
    logic [3:0]         mask_idx;
    logic [31:0]        read_value;
    logic [2:0]         level_hit;
    logic               accept;
    logic               out_free;

    assign accept   = i_valid && !r_skid_vld;
    assign out_free = !r_out_vld || !i_stall;

    // Work out the state after this command, and the read value from the state before it.
    always_comb begin
        cmd        = gism_pkg::t_command'(i_command);
        mask_idx   = i_reg_index - gism_pkg::REG_MASK_BASE;
        n_status   = r_status;
        n_mask     = r_mask;
        read_value = '0;
        case (cmd)
            gism_pkg::CMD_RAISE: begin
                if (i_irq_group != gism_pkg::GROUP_END) begin
                    n_status[i_irq_group] = r_status[i_irq_group] | i_irq_bits;
                end
            end
            gism_pkg::CMD_LOWER: begin
                if (i_irq_group != gism_pkg::GROUP_END) begin
                    n_status[i_irq_group] = r_status[i_irq_group] & ~i_irq_bits;
                end
            end
            gism_pkg::CMD_READ: begin
                if (i_reg_index == gism_pkg::REG_STATUS_NRM) begin
                    // The top two bits summarize the external and error groups.
                    read_value = r_status[gism_pkg::GROUP_NRM] & gism_pkg::NRM_LOW_MASK;
                    if (r_status[gism_pkg::GROUP_EXT] != '0) begin
                        read_value = read_value | gism_pkg::FLAG_EXT;
                    end
                    if (r_status[gism_pkg::GROUP_ERR] != '0) begin
                        read_value = read_value | gism_pkg::FLAG_ERR;
                    end
                end else if (i_reg_index < gism_pkg::REG_MASK_BASE) begin
                    read_value = r_status[i_reg_index[1:0]];
                end else if (i_reg_index < gism_pkg::REG_END) begin
                    read_value = r_mask[mask_idx];
                end
            end
            gism_pkg::CMD_WRITE: begin
                // Status registers are write-one-to-clear; masks load directly.
                if (i_reg_index < gism_pkg::REG_MASK_BASE) begin
                    n_status[i_reg_index[1:0]] = r_status[i_reg_index[1:0]] & ~i_write_data;
                end else if (i_reg_index < gism_pkg::REG_END) begin
                    n_mask[mask_idx] = i_write_data;
                end
            end
            default: begin
                read_value = '0;
            end
        endcase
    end

    // Level requests come from the state as it stands after the command.
    always_comb begin
        for (int lvl = 0; lvl < gism_pkg::LEVELS; lvl++) begin
            level_hit[lvl] = 1'b0;
            for (int g = 0; g < gism_pkg::GROUPS; g++) begin
                level_hit[lvl] = level_hit[lvl] ||
                    ((n_status[g] & n_mask[lvl * gism_pkg::GROUPS + g]) != '0);
            end
        end
        n_result.read_data      = read_value;
        n_result.level2_request = level_hit[0];
        n_result.level4_request = level_hit[1];
        n_result.level6_request = level_hit[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= '{default: '0};
            r_mask     <= '{default: '0};
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_status <= n_status;
                r_mask   <= n_mask;
            end
            if (out_free) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= accept;
                end
            end else if (accept) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // Result payload; only qualified by the valid flags above.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_result;
            end
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_stall          = r_skid_vld;
    assign o_valid          = r_out_vld;
    assign o_read_data      = r_out.read_data;
    assign o_level6_request = r_out.level6_request;
    assign o_level4_request = r_out.level4_request;
    assign o_level2_request = r_out.level2_request;

    `GISM_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid full while output empty")
    `GISM_ASSERT_NEXT(a_stalled_accept_to_skid, i_clk, i_rst_n, accept && r_out_vld && i_stall, r_skid_vld && r_out_vld, "accepted transaction lost under output stall")
    `GISM_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_vld && i_stall, r_skid_vld && $stable(r_skid), "skid entry changed while output stalled")
    `GISM_ASSERT_NEXT(a_w1c_clears_normal, i_clk, i_rst_n, accept && (i_command == gism_pkg::CMD_WRITE) && (i_reg_index == gism_pkg::REG_STATUS_NRM) && (i_write_data == 32'hffff_ffff), r_status[gism_pkg::GROUP_NRM] == '0, "all-ones write did not clear normal status")

endmodule

`default_nettype wire

@@ sim/grouped_interrupt_status_mask_ctrl_test.sv @@
`timescale 1ns / 1ps

module grouped_interrupt_status_mask_ctrl_test;

    // Offsets of each request level inside the nine-entry mask file. Within a level, the
    // groups follow in the order normal, external, error.
    localparam int LVL2_BASE = 0;
    localparam int LVL4_BASE = 3;
    localparam int LVL6_BASE = 6;

    // Number of random commands after the directed opening.
    localparam int RANDOM_CMDS = 1530;

    // One command transaction as the driver presents it. When hold_off is set, the
    // driver keeps the command back until every outstanding result has come home.
    typedef struct {
        gism_pkg::t_command cmd;
        logic [1:0]         grp;
        logic [31:0]        bits;
        logic [3:0]         idx;
        logic [31:0]        data;
        bit                 hold_off;
    } t_irq_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [1:0]  i_command = gism_pkg::CMD_READ;
    logic [1:0]  i_irq_group = gism_pkg::GROUP_NRM;
    logic [31:0] i_irq_bits = '0;
    logic [3:0]  i_reg_index = gism_pkg::REG_STATUS_NRM;
    logic [31:0] i_write_data = '0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_read_data;
    logic        o_level6_request;
    logic        o_level4_request;
    logic        o_level2_request;

    grouped_interrupt_status_mask_ctrl DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_irq_group      (i_irq_group),
        .i_irq_bits       (i_irq_bits),
        .i_reg_index      (i_reg_index),
        .i_write_data     (i_write_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_read_data      (o_read_data),
        .o_level6_request (o_level6_request),
        .o_level4_request (o_level4_request),
        .o_level2_request (o_level2_request)
    );

    // Commands still to be sent, and the results that accepted commands are owed.
    t_irq_cmd          pending_cmds[$];
    gism_pkg::t_result results_due[$];

    // Our own copy of the interrupt state, updated as each command is accepted.
    logic [31:0] irq_status[0:2];
    logic [31:0] lvl_mask[0:8];

    int fail_count = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // A level request is the OR over all three groups of status AND that group's mask.
    function automatic logic level_hit(input int base);
        return |((irq_status[gism_pkg::GROUP_NRM] & lvl_mask[base]) |
                 (irq_status[gism_pkg::GROUP_EXT] & lvl_mask[base + 1]) |
                 (irq_status[gism_pkg::GROUP_ERR] & lvl_mask[base + 2]));
    endfunction

    // Apply one accepted command to the shadow state and queue the result it must produce.
    task automatic apply_irq_cmd(input t_irq_cmd c);
        gism_pkg::t_result r;
        logic [31:0] rd;
        rd = '0;
        case (c.cmd)
            gism_pkg::CMD_RAISE: begin
                // Group three is not backed by any status register and is dropped.
                if (c.grp != gism_pkg::GROUP_END) begin
                    irq_status[c.grp] = irq_status[c.grp] | c.bits;
                end
            end
            gism_pkg::CMD_LOWER: begin
                if (c.grp != gism_pkg::GROUP_END) begin
                    irq_status[c.grp] = irq_status[c.grp] & ~c.bits;
                end
            end
            gism_pkg::CMD_READ: begin
                if (c.idx == gism_pkg::REG_STATUS_NRM) begin
                    // The top two bits of the normal status read back as summary flags of
                    // the other two groups, not as the stored bits.
                    rd = irq_status[gism_pkg::GROUP_NRM] & gism_pkg::NRM_LOW_MASK;
                    if (irq_status[gism_pkg::GROUP_EXT] != '0) rd = rd | gism_pkg::FLAG_EXT;
                    if (irq_status[gism_pkg::GROUP_ERR] != '0) rd = rd | gism_pkg::FLAG_ERR;
                end else if (c.idx < gism_pkg::REG_MASK_BASE) begin
                    rd = irq_status[c.idx];
                end else if (c.idx < gism_pkg::REG_END) begin
                    rd = lvl_mask[c.idx - gism_pkg::REG_MASK_BASE];
                end
            end
            gism_pkg::CMD_WRITE: begin
                // Status registers are write-one-to-clear; masks load the data as is;
                // indexes past the register map are ignored.
                if (c.idx < gism_pkg::REG_MASK_BASE) begin
                    irq_status[c.idx] = irq_status[c.idx] & ~c.data;
                end else if (c.idx < gism_pkg::REG_END) begin
                    lvl_mask[c.idx - gism_pkg::REG_MASK_BASE] = c.data;
                end
            end
            default: begin
                rd = '0;
            end
        endcase
        r.read_data      = rd;
        r.level6_request = level_hit(LVL6_BASE);
        r.level4_request = level_hit(LVL4_BASE);
        r.level2_request = level_hit(LVL2_BASE);
        results_due.push_back(r);
    endtask

    task automatic add_cmd(input gism_pkg::t_command cmd, input logic [1:0] grp,
                           input logic [31:0] bits, input logic [3:0] idx,
                           input logic [31:0] data);
        t_irq_cmd c;
        c.cmd      = cmd;
        c.grp      = grp;
        c.bits     = bits;
        c.idx      = idx;
        c.data     = data;
        c.hold_off = 1'b0;
        pending_cmds.push_back(c);
    endtask

    // Random data words. Fully random words saturate the status quickly, so single bits,
    // holes, sparse words and the two extremes are mixed in to keep the requests toggling.
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(0, 6))
            0:       w = 32'h1 << $urandom_range(0, 31);
            1:       w = ~(32'h1 << $urandom_range(0, 31));
            2:       w = $urandom() & $urandom() & $urandom();
            3:       w = '0;
            4:       w = '1;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // Driver: presents pending commands, predicts each one as it is accepted, and draws a
    // random idle gap after every transaction. Once in a while it switches into a burst
    // mode where no gaps are inserted at all.
    int  send_gap = 0;
    bit  send_burst = 1'b0;

    always @(posedge i_clk) begin
        t_irq_cmd c;
        logic     next_valid;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = i_valid;
            if (i_valid && !o_stall) begin
                c.cmd  = gism_pkg::t_command'(i_command);
                c.grp  = i_irq_group;
                c.bits = i_irq_bits;
                c.idx  = i_reg_index;
                c.data = i_write_data;
                apply_irq_cmd(c);
                next_valid = 1'b0;
                if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 7);
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_cmds.size() > 0 &&
                             (!pending_cmds[0].hold_off ||
                              (results_due.size() == 0 && !i_valid))) begin
                    c = pending_cmds.pop_front();
                    i_command    <= c.cmd;
                    i_irq_group  <= c.grp;
                    i_irq_bits   <= c.bits;
                    i_reg_index  <= c.idx;
                    i_write_data <= c.data;
                    next_valid = 1'b1;
                end
            end
            i_valid <= next_valid;
        end
    end

    // Monitor: compares every accepted result against the oldest prediction, field by
    // field, and after each transaction may hold the result channel stalled for a random
    // stretch, with occasional stretches of no stall at all.
    int  recv_hold = 0;
    bit  recv_burst = 1'b0;

    always @(posedge i_clk) begin
        gism_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            recv_hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, read_data %h", $realtime, o_read_data);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (o_read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $realtime, want.read_data, o_read_data);
                        fail_count++;
                    end
                    if (o_level6_request !== want.level6_request) begin
                        $display("%0t: level6_request expected %b actual %b",
                                 $realtime, want.level6_request, o_level6_request);
                        fail_count++;
                    end
                    if (o_level4_request !== want.level4_request) begin
                        $display("%0t: level4_request expected %b actual %b",
                                 $realtime, want.level4_request, o_level4_request);
                        fail_count++;
                    end
                    if (o_level2_request !== want.level2_request) begin
                        $display("%0t: level2_request expected %b actual %b",
                                 $realtime, want.level2_request, o_level2_request);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
                recv_hold = recv_burst ? 0 : $urandom_range(0, 7);
            end
            if (recv_hold > 0) begin
                i_stall <= 1'b1;
                recv_hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        t_irq_cmd c;
        int sel;
        for (int g = 0; g < gism_pkg::GROUPS; g++) irq_status[g] = '0;
        for (int m = 0; m < gism_pkg::MASKS; m++) lvl_mask[m] = '0;

        // Directed opening. It walks the summary flags of the normal status read, the
        // stored top bits of the normal status, write-one-to-clear, the unused group and
        // the unused register indexes, and the data extremes.
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_WRITE, gism_pkg::GROUP_NRM, '0, gism_pkg::REG_MASK_BASE, '1);
        add_cmd(gism_pkg::CMD_RAISE, gism_pkg::GROUP_NRM, 32'h0000_0001,
                gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_RAISE, gism_pkg::GROUP_EXT, '1, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_RAISE, gism_pkg::GROUP_ERR, gism_pkg::FLAG_ERR,
                gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_RAISE, gism_pkg::GROUP_NRM,
                gism_pkg::FLAG_EXT | gism_pkg::FLAG_ERR, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_WRITE, gism_pkg::GROUP_NRM, '0, gism_pkg::REG_STATUS_NRM,
                gism_pkg::FLAG_EXT | gism_pkg::FLAG_ERR);
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_LOWER, gism_pkg::GROUP_EXT, '1, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_RAISE, gism_pkg::GROUP_END, '1, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_LOWER, gism_pkg::GROUP_END, '1, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0, gism_pkg::REG_END, '0);
        add_cmd(gism_pkg::CMD_WRITE, gism_pkg::GROUP_NRM, '0, 4'hf, '1);
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0, 4'hf, '0);
        add_cmd(gism_pkg::CMD_WRITE, gism_pkg::GROUP_NRM, '0, gism_pkg::REG_END - 4'd1, '1);
        add_cmd(gism_pkg::CMD_WRITE, gism_pkg::GROUP_NRM, '0,
                gism_pkg::REG_MASK_BASE + 4'd5, 32'h0000_0001);
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0, gism_pkg::REG_END - 4'd1, '0);
        add_cmd(gism_pkg::CMD_WRITE, gism_pkg::GROUP_NRM, '0,
                gism_pkg::REG_MASK_BASE - 4'd1, '1);
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0,
                gism_pkg::REG_MASK_BASE - 4'd1, '0);
        add_cmd(gism_pkg::CMD_WRITE, gism_pkg::GROUP_NRM, '0, gism_pkg::REG_MASK_BASE, '0);
        add_cmd(gism_pkg::CMD_LOWER, gism_pkg::GROUP_NRM, '1, gism_pkg::REG_STATUS_NRM, '0);
        add_cmd(gism_pkg::CMD_READ,  gism_pkg::GROUP_NRM, '0,
                gism_pkg::REG_STATUS_NRM + 4'd1, '0);

        // Random part. The command mix leans toward raise and mask writes so that the
        // level requests see both values often; unused fields carry random noise.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 3)      c.cmd = gism_pkg::CMD_RAISE;
            else if (sel < 5) c.cmd = gism_pkg::CMD_LOWER;
            else if (sel < 7) c.cmd = gism_pkg::CMD_READ;
            else              c.cmd = gism_pkg::CMD_WRITE;
            c.grp  = ($urandom_range(0, 9) == 0) ? gism_pkg::GROUP_END
                                                 : 2'($urandom_range(0, 2));
            c.bits = pick_word();
            c.idx  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                 : 4'($urandom_range(0, 11));
            c.data = pick_word();
            // Every few hundred commands the sender drains the block completely first.
            c.hold_off = (n % 300 == 0);
            pending_cmds.push_back(c);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_valid) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        // Give any stray result the chance to show up before the verdict.
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
